>>> rtl/core/stq_pkg.sv
// Shared operation codes and result status codes of the sorted timer queue.
package stq_pkg;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_ADJUST = 2'd1,
        FN_DELETE = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_EXPIRED = 3'd1,
        ST_NONE    = 3'd2,
        ST_FULL    = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_PRESENT = 3'd5
    } status_t;

endpackage

>>> rtl/core/sorted_timer_queue_top.sv
// Sorted timer queue: up to DEPTH timers kept in ascending expiry order in a small memory.
//
// The queue holds up to DEPTH timers (an 8-bit id and an expiry time) in one memory with a
// single write port and a single registered read port, walked by a sequencer one entry per
// cycle, though a tick waits while out_stall holds the output register. One transaction is
// taken at a time; in_stall is high until its last result has been loaded into the output
// register, which may still hold that result while the next transaction is taken. Add looks
// for the id, finds the insert point, moves entries up and writes the new entry. Adjust and
// delete search for the id and may then move entries down; an adjust that moves its timer
// then also goes through the insert steps. Tick removes every expired timer from the front
// by moving the rest down. There is no clearing pass after reset: only entries below the
// count are ever used.
module sorted_timer_queue_top #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  stq_pkg::func_t  func,
    input  logic [7:0]      timer_id,
    input  logic [31:0]     expire_time,
    input  logic [31:0]     now,
    output logic            out_valid,
    input  logic            out_stall,
    output stq_pkg::status_t status,
    output logic [7:0]      expired_id,
    output logic            last
);
    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FIND   = 10'b0000000010,
        S_ADJCHK = 10'b0000000100,
        S_LOCATE = 10'b0000001000,
        S_SHUP   = 10'b0000010000,
        S_PUT    = 10'b0000100000,
        S_SHDN   = 10'b0001000000,
        S_NEXT0  = 10'b0010000000,
        S_TICK   = 10'b0100000000,
        S_RESULT = 10'b1000000000
    } state_t;

    logic [TIME_BITS-1:0] exp_mem [DEPTH];
    logic [7:0]           hdl_mem [DEPTH];

    state_t               state_reg, state_next;
    func_t                op_reg, op_next;
    logic [7:0]           id_reg, id_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        addr_reg, addr_next;
    logic [7:0]           pend_id_reg, pend_id_next;
    logic                 tick_any_reg, tick_any_next;
    status_t              res_status_reg, res_status_next;
    logic [7:0]           res_id_reg, res_id_next;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [7:0]           out_id_reg;
    logic                 out_last_reg;

    logic [TIME_BITS-1:0] rd_exp_reg;
    logic [7:0]           rd_hdl_reg;

    logic                 wr_en;
    logic [CW-1:0]        wr_addr;
    logic [TIME_BITS-1:0] wr_exp;
    logic [7:0]           wr_hdl;

    logic                 out_free;
    logic                 out_load;
    status_t              load_status;
    logic [7:0]           load_id;
    logic                 load_last;

    logic                 do_remove, do_insert;
    logic [CW-1:0]        rm_pos, ins_pos;
    logic [CW-1:0]        idx_inc, cnt_dec;
    logic                 loc_hit;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign expired_id = out_id_reg;
    assign last       = out_last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign idx_inc  = idx_reg + CW'(1);
    assign cnt_dec  = count_reg - CW'(1);
    // At the front a new timer goes first on a tie; further back it goes after equal entries.
    assign loc_hit  = (idx_reg == '0) ? (rd_exp_reg >= exp_reg) : (rd_exp_reg > exp_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        exp_next        = exp_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        pend_id_next    = pend_id_reg;
        tick_any_next   = tick_any_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_exp          = exp_reg;
        wr_hdl          = id_reg;
        out_load        = 1'b0;
        load_status     = res_status_reg;
        load_id         = res_id_reg;
        load_last       = 1'b1;
        do_remove       = 1'b0;
        do_insert       = 1'b0;
        rm_pos          = '0;
        ins_pos         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = func;
                    id_next       = timer_id;
                    exp_next      = TIME_BITS'(expire_time);
                    now_next      = TIME_BITS'(now);
                    idx_next      = '0;
                    addr_next     = '0;
                    tick_any_next = 1'b0;
                    res_id_next   = '0;
                    if (func == FN_TICK)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NONE;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_TICK;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = S_FIND;
                    end
                    else if (func == FN_ADD)
                    begin
                        do_insert = 1'b1;
                        ins_pos   = '0;
                    end
                    else
                    begin
                        res_status_next = ST_ABSENT;
                        state_next      = S_RESULT;
                    end
                end
            end

            S_FIND:
            begin
                if (rd_hdl_reg == id_reg)
                begin
                    pos_next = idx_reg;
                    case (op_reg)
                        FN_ADD:
                        begin
                            res_status_next = ST_PRESENT;
                            state_next      = S_RESULT;
                        end
                        FN_ADJUST:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = idx_reg;
                            if (idx_inc < count_reg)
                            begin
                                addr_next  = idx_inc;
                                state_next = S_ADJCHK;
                            end
                            else
                            begin
                                res_status_next = ST_DONE;
                                state_next      = S_RESULT;
                            end
                        end
                        default:
                        begin
                            do_remove = 1'b1;
                            rm_pos    = idx_reg;
                        end
                    endcase
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next  = idx_inc;
                    addr_next = idx_inc;
                end
                else if (op_reg == FN_ADD)
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        addr_next  = '0;
                        state_next = S_LOCATE;
                    end
                end
                else
                begin
                    res_status_next = ST_ABSENT;
                    state_next      = S_RESULT;
                end
            end

            S_ADJCHK:
            begin
                // The successor slot was read while the new expiry was being written to its own slot.
                if (rd_exp_reg <= exp_reg)
                begin
                    do_remove = 1'b1;
                    rm_pos    = pos_reg;
                end
                else
                begin
                    res_status_next = ST_DONE;
                    state_next      = S_RESULT;
                end
            end

            S_LOCATE:
            begin
                if (loc_hit)
                begin
                    do_insert = 1'b1;
                    ins_pos   = idx_reg;
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next  = idx_inc;
                    addr_next = idx_inc;
                end
                else
                begin
                    do_insert = 1'b1;
                    ins_pos   = count_reg;
                end
            end

            S_SHUP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_inc;
                wr_exp  = rd_exp_reg;
                wr_hdl  = rd_hdl_reg;
                if (idx_reg > pos_reg)
                begin
                    idx_next  = idx_reg - CW'(1);
                    addr_next = idx_reg - CW'(1);
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en           = 1'b1;
                wr_addr         = pos_reg;
                count_next      = count_reg + CW'(1);
                res_status_next = ST_DONE;
                state_next      = S_RESULT;
            end

            S_SHDN:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - CW'(1);
                wr_exp  = rd_exp_reg;
                wr_hdl  = rd_hdl_reg;
                if (idx_inc < count_reg)
                begin
                    idx_next  = idx_inc;
                    addr_next = idx_inc;
                end
                else
                begin
                    count_next = cnt_dec;
                    state_next = S_NEXT0;
                end
            end

            S_NEXT0:
            begin
                // Slot zero may have been written on the previous edge, so it is read again here.
                addr_next = '0;
                idx_next  = '0;
                case (op_reg)
                    FN_TICK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EXPIRED;
                            res_id_next     = pend_id_reg;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_TICK;
                        end
                    end
                    FN_ADJUST:
                    begin
                        if (count_reg == '0)
                        begin
                            do_insert = 1'b1;
                            ins_pos   = '0;
                        end
                        else
                        begin
                            state_next = S_LOCATE;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_DONE;
                        state_next      = S_RESULT;
                    end
                endcase
            end

            S_TICK:
            begin
                if (rd_exp_reg <= now_reg)
                begin
                    // A held expiry is known not to be last once another one is due.
                    if (!tick_any_reg || out_free)
                    begin
                        if (tick_any_reg)
                        begin
                            out_load    = 1'b1;
                            load_status = ST_EXPIRED;
                            load_id     = pend_id_reg;
                            load_last   = 1'b0;
                        end
                        pend_id_next  = rd_hdl_reg;
                        tick_any_next = 1'b1;
                        do_remove     = 1'b1;
                        rm_pos        = '0;
                    end
                end
                else if (tick_any_reg)
                begin
                    res_status_next = ST_EXPIRED;
                    res_id_next     = pend_id_reg;
                    state_next      = S_RESULT;
                end
                else
                begin
                    res_status_next = ST_NONE;
                    state_next      = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_remove)
        begin
            pos_next = rm_pos;
            if ((rm_pos + CW'(1)) < count_reg)
            begin
                idx_next   = rm_pos + CW'(1);
                addr_next  = rm_pos + CW'(1);
                state_next = S_SHDN;
            end
            else
            begin
                count_next = cnt_dec;
                state_next = S_NEXT0;
            end
        end

        if (do_insert)
        begin
            pos_next = ins_pos;
            if (count_reg > ins_pos)
            begin
                idx_next   = cnt_dec;
                addr_next  = cnt_dec;
                state_next = S_SHUP;
            end
            else
            begin
                state_next = S_PUT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            exp_mem[wr_addr[AW-1:0]] <= wr_exp;
            hdl_mem[wr_addr[AW-1:0]] <= wr_hdl;
        end
        rd_exp_reg <= exp_mem[addr_next[AW-1:0]];
        rd_hdl_reg <= hdl_mem[addr_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tick_any_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tick_any_reg <= tick_any_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        exp_reg        <= exp_next;
        now_reg        <= now_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        addr_reg       <= addr_next;
        pend_id_reg    <= pend_id_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            out_status_reg <= load_status;
            out_id_reg     <= load_id;
            out_last_reg   <= load_last;
        end
    end

endmodule
